### design/pipt_pkg.sv
// shared types and constants of the point-in-polygon test unit
package pipt_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int COORD_WIDTH_DEF  = 32;
	localparam int FIELD_COORD_W    = 32;
	localparam int INDEX_W          = 4;
	localparam int VCOUNT_W         = 5;
	localparam int QUEUE_DEPTH      = 4;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TEST  = 1'b1
	} op_t;

	// one classified transaction as it sits in the queue
	typedef struct packed {
		op_t                              op;
		logic                             wr_en;
		logic [INDEX_W-1:0]               idx;
		logic signed [FIELD_COORD_W-1:0]  x;
		logic signed [FIELD_COORD_W-1:0]  y;
		logic [VCOUNT_W-1:0]              n;
	} item_t;

endpackage

### design/pipt_front.sv
// front end: accepts transactions and classifies them for the queue
module pipt_front #(
	parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = pipt_pkg::COORD_WIDTH_DEF
) (
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [0:0]                             opcode,
	input  logic [pipt_pkg::INDEX_W-1:0]           vertex_index,
	input  logic signed [pipt_pkg::FIELD_COORD_W-1:0] coord_x,
	input  logic signed [pipt_pkg::FIELD_COORD_W-1:0] coord_y,
	input  logic [pipt_pkg::VCOUNT_W-1:0]          vertex_count,
	input  logic                                   q_full,
	output logic                                   q_push,
	output pipt_pkg::item_t                        q_item
);

	localparam int FW = pipt_pkg::FIELD_COORD_W;
	localparam int VW = pipt_pkg::VCOUNT_W;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item.op    = pipt_pkg::op_t'(opcode);
		// slots beyond the store are dropped
		q_item.wr_en = (32'(vertex_index) < 32'(MAX_VERTICES));
		q_item.idx   = vertex_index;
		// keep the low coordinate bits, read as two's complement
		q_item.x     = FW'($signed(coord_x[COORD_WIDTH-1:0]));
		q_item.y     = FW'($signed(coord_y[COORD_WIDTH-1:0]));
		// oversized counts saturate to the store depth
		q_item.n     = (32'(vertex_count) > 32'(MAX_VERTICES)) ? VW'(MAX_VERTICES)
			: vertex_count;
	end

endmodule

### design/pipt_queue.sv
// short fifo between front end and back end
module pipt_queue #(
	parameter int DEPTH = pipt_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pipt_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output pipt_pkg::item_t head_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pipt_pkg::item_t entries_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;

	assign full       = (fill_q == CW'(DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

### design/pipt_back.sv
// back end: vertex store, edge walk pipeline and result register
module pipt_back #(
	parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = pipt_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  pipt_pkg::item_t               q_item,
	output logic                          q_pop,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          res_inside,
	output logic [pipt_pkg::VCOUNT_W-1:0] res_count
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int VW = pipt_pkg::VCOUNT_W;
	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t state_q;

	logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
	logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];

	logic signed [COORD_WIDTH-1:0] px_q, py_q;
	logic [VW-1:0]                 n_q, k_q, count_q;
	logic                          res_valid_q, res_inside_q;
	logic [VW-1:0]                 res_count_q;

	logic                          rd_en;
	logic [AW-1:0]                 rd_addr;

	// stage 1: read data
	logic                          rdv_s1, edge_s1, last_s1;
	logic signed [COORD_WIDTH-1:0] rd_x_s1, rd_y_s1;
	logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;

	// stage 2: differences and flags
	logic                          valid_s2, last_s2, ywin_s2, vert_s2, left_s2, dyneg_s2;
	logic signed [DW-1:0]          dx_s2, dy_s2, a1_s2, b1_s2;

	// stage 3: products
	logic                          valid_s3, last_s3, ywin_s3, vert_s3, left_s3, dyneg_s3;
	logic signed [PW-1:0]          prod_a_s3, prod_b_s3;

	logic signed [DW-1:0]          xi, yi, xj, yj, pxe, pye;
	logic                          ywin;
	logic signed [SW-1:0]          sum_s3;
	logic                          hit_s3;

	assign q_pop   = (state_q == ST_IDLE) && q_valid;
	assign rd_en   = (state_q == ST_RUN);
	// the closing edge reads vertex 0 again
	assign rd_addr = AW'((k_q == n_q) ? '0 : k_q);

	assign res_valid  = res_valid_q;
	assign res_inside = res_inside_q;
	assign res_count  = res_count_q;

	// vertex store
	always_ff @(posedge clk) begin
		if (q_pop && q_item.op == pipt_pkg::OP_WRITE && q_item.wr_en) begin
			mem_x[AW'(q_item.idx)] <= q_item.x[COORD_WIDTH-1:0];
			mem_y[AW'(q_item.idx)] <= q_item.y[COORD_WIDTH-1:0];
		end
		if (rd_en) begin
			rd_x_s1 <= mem_x[rd_addr];
			rd_y_s1 <= mem_y[rd_addr];
		end
	end

	// edge i runs from the previous vertex to the one just read
	always_comb begin
		xi  = DW'(prev_x_q);
		yi  = DW'(prev_y_q);
		xj  = DW'(rd_x_s1);
		yj  = DW'(rd_y_s1);
		pxe = DW'(px_q);
		pye = DW'(py_q);
		if (prev_y_q > rd_y_s1) begin
			ywin = (py_q <= prev_y_q) && (py_q >= rd_y_s1);
		end else if (rd_y_s1 > prev_y_q) begin
			ywin = (py_q <= rd_y_s1) && (py_q >= prev_y_q);
		end else begin
			ywin = 1'b0;
		end
	end

	// sloped edge crossing at or right of point if a*dy + b*dx has dy's sign or is zero
	always_comb begin
		sum_s3 = SW'(prod_a_s3) + SW'(prod_b_s3);
		if (vert_s3) begin
			hit_s3 = ywin_s3 && left_s3;
		end else if (dyneg_s3) begin
			hit_s3 = ywin_s3 && (sum_s3 <= 0);
		end else begin
			hit_s3 = ywin_s3 && (sum_s3 >= 0);
		end
	end

	always_ff @(posedge clk) begin
		if (rdv_s1) begin
			prev_x_q <= rd_x_s1;
			prev_y_q <= rd_y_s1;
		end
		last_s2  <= last_s1;
		ywin_s2  <= ywin;
		vert_s2  <= (prev_x_q == rd_x_s1);
		left_s2  <= (px_q < prev_x_q);
		dx_s2    <= xi - xj;
		dy_s2    <= yi - yj;
		dyneg_s2 <= (yi < yj);
		a1_s2    <= xi - pxe;
		b1_s2    <= pye - yi;

		last_s3   <= last_s2;
		ywin_s3   <= ywin_s2;
		vert_s3   <= vert_s2;
		left_s3   <= left_s2;
		dyneg_s3  <= dyneg_s2;
		prod_a_s3 <= PW'(a1_s2) * PW'(dy_s2);
		prod_b_s3 <= PW'(b1_s2) * PW'(dx_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1   <= 1'b0;
			edge_s1  <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			rdv_s1   <= rd_en;
			edge_s1  <= rd_en && (k_q != '0);
			last_s1  <= rd_en && (k_q == n_q);
			valid_s2 <= rdv_s1 && edge_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			px_q         <= '0;
			py_q         <= '0;
			n_q          <= '0;
			k_q          <= '0;
			count_q      <= '0;
			res_valid_q  <= 1'b0;
			res_inside_q <= 1'b0;
			res_count_q  <= '0;
		end else begin
			// in ST_FIN the result load decides res_valid_q
			if (res_valid_q && res_ready && state_q != ST_FIN) begin
				res_valid_q <= 1'b0;
			end
			if (valid_s3 && hit_s3) begin
				count_q <= count_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.op == pipt_pkg::OP_TEST) begin
						px_q    <= q_item.x[COORD_WIDTH-1:0];
						py_q    <= q_item.y[COORD_WIDTH-1:0];
						n_q     <= q_item.n;
						k_q     <= '0;
						count_q <= '0;
						state_q <= (q_item.n == '0) ? ST_FIN : ST_RUN;
					end
				end
				ST_RUN: begin
					k_q <= k_q + 1'b1;
					if (k_q == n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (valid_s3 && last_s3) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q  <= 1'b1;
						res_inside_q <= count_q[0];
						res_count_q  <= count_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/point_in_polygon_test_unit.sv
// top level of the point-in-polygon test unit
//
// input channel (in_valid / in_ready): one transaction per accepted edge.
//   opcode write stores coord_x / coord_y at vertex_index, opcode test casts
//   a ray toward +x from (coord_x, coord_y) over the first vertex_count vertices
// output channel (out_valid / out_ready): one result per test transaction,
//   none per write; inside_res is the low bit of crossing_count
// the front end takes a transaction every cycle while its four-entry queue
//   has room; the back end drains the queue one transaction at a time
// a write occupies the back end only for the pop
// a test with a nonzero (saturated) count occupies it for the pop, one store
//   read per vertex plus the closing re-read of vertex 0, the drain through the
//   read, difference and multiply stages with the sign compare, then the result
//   load; a zero count goes from the pop straight to the result load
// the store reads set the pace; with the back end free, out_valid rises
//   with the result load, later if the queue holds work
// when the receiver stalls, the result stays in the output register, the back
//   end holds its next result, and the queue fills before in_ready drops
// reset clears the queue, the sequencer and the output register; the vertex
//   store is not cleared, so every vertex a test uses must be written first
module point_in_polygon_test_unit #(
	parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = pipt_pkg::COORD_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [0:0]                                opcode,
	input  logic [pipt_pkg::INDEX_W-1:0]              vertex_index,
	input  logic signed [pipt_pkg::FIELD_COORD_W-1:0] coord_x,
	input  logic signed [pipt_pkg::FIELD_COORD_W-1:0] coord_y,
	input  logic [pipt_pkg::VCOUNT_W-1:0]             vertex_count,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic                                      inside_res,
	output logic [pipt_pkg::VCOUNT_W-1:0]             crossing_count
);

	// front end to queue
	logic            q_full;
	logic            q_push;
	pipt_pkg::item_t q_push_item;

	// queue to back end
	logic            q_pop;
	logic            q_valid;
	pipt_pkg::item_t q_head_item;

	pipt_front #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.vertex_index(vertex_index),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.vertex_count(vertex_count),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_push_item)
	);

	// decouples acceptance from the edge walk
	pipt_queue #(
		.DEPTH(pipt_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_item (q_head_item)
	);

	// vertex store, edge pipeline and output register
	pipt_back #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_head_item),
		.q_pop     (q_pop),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res_inside(inside_res),
		.res_count (crossing_count)
	);

endmodule

### design/pipt_checker.sv
// port-level checker of the point-in-polygon test unit and its bind
module pipt_checker #(
	parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [0:0]                    opcode,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          inside_res,
	input logic [pipt_pkg::VCOUNT_W-1:0] crossing_count
);

	logic [7:0] pending_q;
	logic       test_in;
	logic       res_out;

	assign test_in = in_valid && in_ready && (opcode == 1'(pipt_pkg::OP_TEST));
	assign res_out = out_valid && out_ready;

	// tests accepted whose result has not been delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (test_in && !res_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (res_out && !test_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(inside_res) && $stable(crossing_count))
		else $error("result changed while stalled");

	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inside_res == crossing_count[0])
		else $error("inside flag disagrees with crossing parity");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(crossing_count) <= 32'(MAX_VERTICES))
		else $error("crossing count above vertex limit");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result without an outstanding test");

endmodule

bind point_in_polygon_test_unit pipt_checker #(
	.MAX_VERTICES(MAX_VERTICES)
) u_pipt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.opcode        (opcode),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.inside_res    (inside_res),
	.crossing_count(crossing_count)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the point-in-polygon test unit
module testbench;
	import pipt_pkg::*;

	localparam int NV       = MAX_VERTICES_DEF;
	localparam int CW       = FIELD_COORD_W;
	localparam int IDLE_PCT = 32;
	// margin covering the longest test through the back end and the output register
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS   = 10;

	// what one test transaction should produce
	typedef struct packed {
		logic                in_poly;
		logic [VCOUNT_W-1:0] crossings;
	} verdict_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    in_valid     = 1'b0;
	logic                    in_ready;
	logic [0:0]              opcode       = OP_WRITE;
	logic [INDEX_W-1:0]      vertex_index = '0;
	logic signed [CW-1:0]    coord_x      = '0;
	logic signed [CW-1:0]    coord_y      = '0;
	logic [VCOUNT_W-1:0]     vertex_count = '0;
	logic                    out_valid;
	logic                    out_ready    = 1'b0;
	logic                    inside_res;
	logic [VCOUNT_W-1:0]     crossing_count;

	// local copy of the vertex store, updated when a write transaction is accepted
	logic signed [CW-1:0]    vx_mirror [NV];
	logic signed [CW-1:0]    vy_mirror [NV];
	verdict_t                pending_verdicts [$];

	bit idle_on   = 1'b1;   // random idling on both channels
	bit sink_hold = 1'b0;   // receiver refuses every result while set
	int n_writes, n_tests, n_inside, n_checked, n_mismatch, max_crossings;

	always #2 clk = ~clk;

	point_in_polygon_test_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.vertex_index   (vertex_index),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.vertex_count   (vertex_count),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.inside_res     (inside_res),
		.crossing_count (crossing_count)
	);

	// ray toward +x over the first n stored vertices, exact integer arithmetic
	// products of 33-bit differences need 66 bits, so everything runs at 70
	function automatic verdict_t ray_crossings(logic signed [CW-1:0] px,
			logic signed [CW-1:0] py, logic [VCOUNT_W-1:0] n_raw);
		logic signed [69:0] xi, yi, xj, yj, qx, qy, dx, dy, sum;
		int n, j, cnt;
		bit spans;
		verdict_t v;
		n   = (n_raw > NV) ? NV : int'(n_raw);   // oversized count saturates
		cnt = 0;
		qx  = px;
		qy  = py;
		for (int i = 0; i < n; i++) begin
			j  = (i + 1 == n) ? 0 : i + 1;      // last edge closes to vertex 0
			xi = vx_mirror[i];
			yi = vy_mirror[i];
			xj = vx_mirror[j];
			yj = vy_mirror[j];
			// y ends must differ, point y inclusive between them
			spans = (yi > yj && qy <= yi && qy >= yj) || (yj > yi && qy <= yj && qy >= yi);
			if (spans) begin
				if (xi == xj) begin
					// vertical edge: strictly left of it
					if (qx < xi)
						cnt++;
				end else begin
					// crossing x at or right of the point, without the division
					dx  = xi - xj;
					dy  = yi - yj;
					sum = (xi - qx) * dy + (qy - yi) * dx;
					if ((dy > 0 && sum >= 0) || (dy < 0 && sum <= 0))
						cnt++;
				end
			end
		end
		v.in_poly   = cnt[0];
		v.crossings = cnt[VCOUNT_W-1:0];
		return v;
	endfunction

	task automatic note_mismatch(string what);
		n_mismatch++;
		if (n_mismatch <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// one input transaction: optional idle gap, then hold valid until accepted
	task automatic push_txn(op_t op, logic [INDEX_W-1:0] idx, logic signed [CW-1:0] x,
			logic signed [CW-1:0] y, logic [VCOUNT_W-1:0] n);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(99) < IDLE_PCT)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		vertex_index <= idx;
		coord_x      <= x;
		coord_y      <= y;
		vertex_count <= n;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// accepted at this edge: update the model in acceptance order
		if (op == OP_WRITE) begin
			vx_mirror[idx] = x;
			vy_mirror[idx] = y;
			n_writes++;
		end else begin
			pending_verdicts.push_back(ray_crossings(x, y, n));
			n_tests++;
		end
	endtask

	// the ignored field of each kind gets random content
	task automatic put_vertex(int idx, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
		push_txn(OP_WRITE, idx[INDEX_W-1:0], x, y, VCOUNT_W'($urandom));
	endtask

	task automatic query_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, int n);
		push_txn(OP_TEST, INDEX_W'($urandom), x, y, n[VCOUNT_W-1:0]);
	endtask

	// stop sending and wait for every outstanding result
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	// small grid coordinates hit vertices, edges, vertical and horizontal edges;
	// wide ones exercise the full products
	function automatic logic signed [CW-1:0] pick_coord(bit wide);
		logic signed [CW-1:0] c;
		case ($urandom_range(9))
			0:       c = 32'sh8000_0000;
			1:       c = 32'sh7fff_ffff;
			2, 3:    c = $urandom;
			default: c = wide ? $signed($urandom) : $signed($urandom_range(40)) - 20;
		endcase
		return c;
	endfunction

	// receiver: random stalls, none while idling is off, all while held
	always @(posedge clk)
		out_ready <= !sink_hold && (!idle_on || $urandom_range(99) >= IDLE_PCT);

	// result checker, compares each accepted result with the oldest verdict
	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				note_mismatch($sformatf("result with nothing pending: inside %0b count %0d",
					inside_res, crossing_count));
			end else begin
				want = pending_verdicts.pop_front();
				n_checked++;
				if (inside_res !== want.in_poly || crossing_count !== want.crossings)
					note_mismatch($sformatf("inside exp %0b got %0b, count exp %0d got %0d",
						want.in_poly, inside_res, want.crossings, crossing_count));
				if (want.in_poly)
					n_inside++;
				if (want.crossings > max_crossings)
					max_crossings = want.crossings;
			end
		end
	end

	// square at the coordinate extremes, covering vertical and horizontal edges,
	// points on corners and edges, and the empty and degenerate counts
	task automatic test_square_extremes();
		put_vertex(0, 32'sh8000_0000, 32'sh8000_0000);
		put_vertex(1, 32'sh7fff_ffff, 32'sh8000_0000);
		put_vertex(2, 32'sh7fff_ffff, 32'sh7fff_ffff);
		put_vertex(3, 32'sh8000_0000, 32'sh7fff_ffff);
		query_point(0, 0, 4);
		query_point(32'sh8000_0000, 32'sh8000_0000, 4);
		query_point(32'sh7fff_ffff, 32'sh7fff_ffff, 4);
		query_point(32'sh8000_0000, 0, 4);
		query_point(32'sh7fff_ffff, -1, 4);
		query_point(0, 0, 0);     // empty polygon
		query_point(0, 0, 1);     // single degenerate edge
		query_point(-5, 3, 2);
		query_point(7, -9, 3);
	endtask

	// fill every slot, then counts at, above and far above the store size
	task automatic test_count_limits();
		for (int k = 4; k < NV; k++)
			put_vertex(k, pick_coord(k[0]), pick_coord(k[0]));
		query_point(1, 1, NV);
		query_point(-3, 2, NV + 1);
		query_point(pick_coord(1'b1), pick_coord(1'b1), 31);
	endtask

	// hold the receiver so the output register and the queue fill and in_ready drops
	task automatic test_backpressure();
		idle_on   = 1'b0;
		sink_hold = 1'b1;
		fork
			begin
				repeat (150) @(posedge clk);
				sink_hold = 1'b0;
			end
		join_none
		for (int k = 0; k < 8; k++)
			query_point(pick_coord(1'b0), pick_coord(1'b0), 3);
		put_vertex(3, 32'sh8000_0000, 32'sh7fff_ffff);
		query_point(0, 0, 4);
		wait_drained();
		idle_on = 1'b1;
	endtask

	// random polygons written in shuffled order, then queries against them;
	// some queries use unrelated counts over whatever the store holds
	task automatic test_random_polygons(int items);
		int sent, n, tests, sel, tmp, cnt;
		int order [NV];
		bit wide;
		logic signed [CW-1:0] px, py;
		sent = 0;
		while (sent < items) begin
			n    = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, NV);
			wide = $urandom_range(1);
			for (int k = 0; k < NV; k++)
				order[k] = k;
			for (int k = n - 1; k > 0; k--) begin
				sel        = $urandom_range(k);
				tmp        = order[k];
				order[k]   = order[sel];
				order[sel] = tmp;
			end
			for (int k = 0; k < n; k++)
				put_vertex(order[k], pick_coord(wide), pick_coord(wide));
			sent += n;
			// stray write into an unused slot, store stays fully written
			if (n < NV && $urandom_range(3) == 0) begin
				put_vertex($urandom_range(n, NV - 1), pick_coord(1'b1), pick_coord(1'b1));
				sent++;
			end
			tests = $urandom_range(1, 6);
			for (int t = 0; t < tests; t++) begin
				sel = $urandom_range(9);
				if (sel < 4) begin
					// snap to a stored vertex, sometimes nudged by one
					tmp = $urandom_range(n - 1);
					px  = vx_mirror[tmp] + ($signed($urandom_range(2)) - 1);
					py  = vy_mirror[tmp] + ($signed($urandom_range(2)) - 1);
				end else begin
					px = pick_coord(wide);
					py = pick_coord(wide);
				end
				case ($urandom_range(9))
					0:       cnt = $urandom_range(31);
					1:       cnt = $urandom_range(n);
					default: cnt = n;
				endcase
				query_point(px, py, cnt);
				sent++;
			end
		end
	endtask

	initial begin
		n_writes      = 0;
		n_tests       = 0;
		n_inside      = 0;
		n_checked     = 0;
		n_mismatch    = 0;
		max_crossings = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_square_extremes();
		test_count_limits();
		test_backpressure();
		test_random_polygons(280);
		// sender pauses until every result has come back
		wait_drained();
		// long stretch with no idling on either side
		idle_on = 1'b0;
		test_random_polygons(130);
		idle_on = 1'b1;
		test_random_polygons(90);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_verdicts.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
		$display("covered %0d vertex writes and %0d point tests, %0d results checked",
			n_writes, n_tests, n_checked);
		$display("%0d points inside, largest crossing count %0d, %0d mismatches",
			n_inside, max_crossings, n_mismatch);
		if (n_mismatch == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
design/pipt_pkg.sv
design/pipt_front.sv
design/pipt_queue.sv
design/pipt_back.sv
design/point_in_polygon_test_unit.sv
design/pipt_checker.sv
tb/testbench.sv
